/* rtl/mdc_pkg.sv */
`default_nettype none
package mdc_pkg;

    // Geometry of the cache and the address split.
    localparam int ADDR_W          = 20;
    localparam int DATA_W          = 32;
    localparam int NUM_SETS        = 64;
    localparam int WORDS_PER_BLOCK = 4;
    localparam int TAG_W           = 12;
    localparam int SET_W           = $clog2(NUM_SETS);
    localparam int WORD_W          = $clog2(WORDS_PER_BLOCK);
    localparam int OFF_W           = SET_W + WORD_W;
    localparam int NUM_SLOTS       = NUM_SETS * WORDS_PER_BLOCK;

    // Field widths of the channels.
    localparam int ACTION_W  = 2;
    localparam int ORIGIN_W  = 3;
    localparam int CMD_W     = 2;
    localparam int REQ_W     = 2;
    localparam int CORE_ID_W = 2;

    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS_PER_BLOCK - 1);

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SNOOP = 2'd2;

    // Bus commands.
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RDX   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

    // Bus requests issued by this cache.
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RDX  = 2'd2;

    // Bus origin of main memory.
    localparam logic [ORIGIN_W-1:0] ORIGIN_MEM = 3'd4;

    typedef enum logic [1:0] {
        MESI_I = 2'd0,
        MESI_S = 2'd1,
        MESI_E = 2'd2,
        MESI_M = 2'd3
    } mesi_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FREAD,
        ST_FEMIT
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   word_data;
        logic                bus_grant;
        logic [ORIGIN_W-1:0] bus_origin;
        logic [CMD_W-1:0]    bus_command;
        logic                shared_line;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
        logic [REQ_W-1:0]  bus_request;
        logic              flush_valid;
        logic [ADDR_W-1:0] flush_addr;
        logic [DATA_W-1:0] flush_data;
        logic              last;
    } out_item_t;

    // One entry of the tag store: tag and coherence state.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        mesi_t            state;
    } line_t;

    typedef struct packed {
        logic             en;
        logic [SET_W-1:0] set;
        line_t            line;
    } tag_wr_t;

    typedef struct packed {
        logic              en;
        logic [OFF_W-1:0]  slot;
        logic [DATA_W-1:0] data;
    } data_wr_t;

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] addr);
        return addr[OFF_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] word_of(input logic [ADDR_W-1:0] addr);
        return addr[WORD_W-1:0];
    endfunction

    function automatic logic [OFF_W-1:0] slot_of(input logic [ADDR_W-1:0] addr);
        return addr[OFF_W-1:0];
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+TAG_W-1:0] wide;
        wide = {{TAG_W{1'b0}}, addr} >> OFF_W;
        return wide[TAG_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr(input logic [ADDR_W-1:0] addr);
        return {addr[ADDR_W-1:WORD_W], {WORD_W{1'b0}}};
    endfunction

    // Word address rebuilt from a stored tag, a set and a word number.
    function automatic logic [ADDR_W-1:0] flush_addr(
        input logic [TAG_W-1:0]  tag,
        input logic [SET_W-1:0]  set,
        input logic [WORD_W-1:0] word
    );
        logic [TAG_W+OFF_W+ADDR_W-1:0] full;
        full = {{ADDR_W{1'b0}}, tag, set, word};
        return full[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/mdc_tag_mem.sv */
`default_nettype none
module mdc_tag_mem (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       rd_en,
    input  wire logic [mdc_pkg::SET_W-1:0]  rd_set,
    output mdc_pkg::line_t                  rd_line,
    input  mdc_pkg::tag_wr_t                wr
);

    mdc_pkg::line_t                  line_mem_reg [mdc_pkg::NUM_SETS];
    logic [mdc_pkg::NUM_SETS-1:0]    valid_reg;
    mdc_pkg::line_t                  rd_raw_reg;
    logic                            rd_valid_reg;

    // Storage array with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            line_mem_reg[wr.set] <= wr.line;
        end
        if (rd_en) begin
            rd_raw_reg <= line_mem_reg[rd_set];
        end
    end

    // A set that was never written reads as tag zero, state invalid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.set] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_set];
            end
        end
    end

    assign rd_line = rd_valid_reg ? rd_raw_reg
                                  : mdc_pkg::line_t'{tag: '0, state: mdc_pkg::MESI_I};

endmodule
`default_nettype wire

/* rtl/mdc_data_mem.sv */
`default_nettype none
module mdc_data_mem (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [mdc_pkg::OFF_W-1:0]   rd_slot,
    output logic [mdc_pkg::DATA_W-1:0]       rd_data,
    input  mdc_pkg::data_wr_t                wr
);

    logic [mdc_pkg::DATA_W-1:0]      data_mem_reg [mdc_pkg::NUM_SLOTS];
    logic [mdc_pkg::NUM_SLOTS-1:0]   valid_reg;
    logic [mdc_pkg::DATA_W-1:0]      rd_raw_reg;
    logic                            rd_valid_reg;

    // Storage array with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            data_mem_reg[wr.slot] <= wr.data;
        end
        if (rd_en) begin
            rd_raw_reg <= data_mem_reg[rd_slot];
        end
    end

    // One valid bit per word, so an unwritten word reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.slot] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_slot];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule
`default_nettype wire

/* rtl/mesi_direct_mapped_cache.sv */
`default_nettype none
// Channel   Ports                         Direction  Moves
// input     s_valid s_ready s_item        in         one access or snooped bus transaction
// result    m_valid m_ready m_item        out        one result, last marks the final one
// config    cfg_valid cfg_ready cfg_data  in         own core id
//
// On accept, an item reads the tag and data memories; the decide step then writes
// back and loads the output register.
// A snoop that flushes a modified block adds a data memory read and then an output
// load for each word of the block.
// Reset clears the control state and the store valid bits.
// A stalled result holds the block in its decide or flush step until transferred.
module mesi_direct_mapped_cache (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  mdc_pkg::in_item_t                    s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output mdc_pkg::out_item_t                   m_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mdc_pkg::CORE_ID_W-1:0]   cfg_data
);

    mdc_pkg::state_t                     state_reg, state_next;
    mdc_pkg::in_item_t                   item_reg;
    logic [mdc_pkg::WORD_W-1:0]          word_cnt_reg, word_cnt_next;
    logic [mdc_pkg::CORE_ID_W-1:0]       own_id_reg;
    logic [mdc_pkg::ADDR_W-1:0]          pend_addr_reg, pend_addr_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic                                m_valid_reg, m_valid_next;
    mdc_pkg::out_item_t                  m_item_reg, m_item_next;

    logic                                s_xfer;
    logic                                out_free;
    logic                                found;
    logic                                need_bus;
    logic                                flush_start;
    logic [mdc_pkg::TAG_W-1:0]           item_tag;
    logic [mdc_pkg::SET_W-1:0]           item_set;
    mdc_pkg::out_item_t                  look_res;
    mdc_pkg::out_item_t                  flush_res;
    mdc_pkg::tag_wr_t                    tag_wr, tag_wr_look;
    mdc_pkg::data_wr_t                   data_wr, data_wr_look;
    mdc_pkg::line_t                      rd_line;
    logic                                data_rd_en;
    logic [mdc_pkg::OFF_W-1:0]           data_rd_slot;
    logic [mdc_pkg::DATA_W-1:0]          rd_data;
    logic [mdc_pkg::ADDR_W-1:0]          pend_addr_look;
    logic                                pend_valid_look;

    assign s_ready   = (state_reg == mdc_pkg::ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign item_tag = mdc_pkg::tag_of(item_reg.addr);
    assign item_set = mdc_pkg::set_of(item_reg.addr);

    // Memories: tag and state per set, data per word.
    mdc_tag_mem u_tag_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .rd_set  (mdc_pkg::set_of(s_item.addr)),
        .rd_line (rd_line),
        .wr      (tag_wr)
    );

    assign data_rd_en   = s_xfer || (state_reg == mdc_pkg::ST_FREAD);
    assign data_rd_slot = (state_reg == mdc_pkg::ST_FREAD) ? {item_set, word_cnt_reg}
                                                           : mdc_pkg::slot_of(s_item.addr);

    mdc_data_mem u_data_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (data_rd_en),
        .rd_slot (data_rd_slot),
        .rd_data (rd_data),
        .wr      (data_wr)
    );

    // Decision for the item read in the accept cycle.
    always_comb begin
        found = (rd_line.tag == item_tag) && (rd_line.state != mdc_pkg::MESI_I);
        need_bus        = !(found && (rd_line.state == mdc_pkg::MESI_M ||
                                      rd_line.state == mdc_pkg::MESI_E));
        flush_start     = 1'b0;
        look_res        = '0;
        look_res.last   = 1'b1;
        tag_wr_look     = '0;
        tag_wr_look.set = item_set;
        data_wr_look      = '0;
        data_wr_look.slot = mdc_pkg::slot_of(item_reg.addr);
        data_wr_look.data = item_reg.word_data;
        pend_addr_look  = pend_addr_reg;
        pend_valid_look = pend_valid_reg;

        case (item_reg.action)
            mdc_pkg::ACT_READ: begin
                if (found) begin
                    look_res.hit       = 1'b1;
                    look_res.read_data = rd_data;
                end else begin
                    look_res.bus_request = mdc_pkg::REQ_READ;
                    if (item_reg.bus_grant) begin
                        pend_addr_look  = mdc_pkg::block_addr(item_reg.addr);
                        pend_valid_look = 1'b1;
                    end
                end
            end
            mdc_pkg::ACT_WRITE: begin
                if (need_bus) begin
                    look_res.bus_request = mdc_pkg::REQ_RDX;
                end
                if (!need_bus || item_reg.bus_grant) begin
                    look_res.hit     = 1'b1;
                    data_wr_look.en  = 1'b1;
                    tag_wr_look.en   = 1'b1;
                    tag_wr_look.line = '{tag: item_tag, state: mdc_pkg::MESI_M};
                end
            end
            mdc_pkg::ACT_SNOOP: begin
                if (item_reg.bus_origin != {1'b0, own_id_reg}) begin
                    if (item_reg.bus_origin == mdc_pkg::ORIGIN_MEM) begin
                        // Fill word from memory at the pending address.
                        if (item_reg.bus_command == mdc_pkg::CMD_FLUSH && pend_valid_reg &&
                            item_reg.addr == pend_addr_reg) begin
                            data_wr_look.en = 1'b1;
                            if (mdc_pkg::word_of(item_reg.addr) == mdc_pkg::LAST_WORD) begin
                                tag_wr_look.en   = 1'b1;
                                tag_wr_look.line.tag = item_tag;
                                tag_wr_look.line.state = item_reg.shared_line ?
                                                         mdc_pkg::MESI_S : mdc_pkg::MESI_E;
                                pend_valid_look  = 1'b0;
                            end else begin
                                pend_addr_look = pend_addr_reg + mdc_pkg::ADDR_W'(1);
                            end
                        end
                    end else if (item_reg.bus_origin < mdc_pkg::ORIGIN_MEM && found) begin
                        // Another core's access demotes or invalidates our copy.
                        tag_wr_look.line.tag = rd_line.tag;
                        if (rd_line.state == mdc_pkg::MESI_M &&
                            (item_reg.bus_command == mdc_pkg::CMD_READ ||
                             item_reg.bus_command == mdc_pkg::CMD_RDX)) begin
                            flush_start     = 1'b1;
                            tag_wr_look.en  = 1'b1;
                            tag_wr_look.line.state =
                                (item_reg.bus_command == mdc_pkg::CMD_READ) ?
                                mdc_pkg::MESI_S : mdc_pkg::MESI_I;
                        end else if (rd_line.state == mdc_pkg::MESI_E &&
                                     item_reg.bus_command == mdc_pkg::CMD_READ) begin
                            tag_wr_look.en         = 1'b1;
                            tag_wr_look.line.state = mdc_pkg::MESI_S;
                        end else if ((rd_line.state == mdc_pkg::MESI_E ||
                                      rd_line.state == mdc_pkg::MESI_S) &&
                                     item_reg.bus_command == mdc_pkg::CMD_RDX) begin
                            tag_wr_look.en         = 1'b1;
                            tag_wr_look.line.state = mdc_pkg::MESI_I;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // One word of a modified block flush.
    always_comb begin
        flush_res             = '0;
        flush_res.flush_valid = 1'b1;
        flush_res.flush_addr  = mdc_pkg::flush_addr(rd_line.tag, item_set, word_cnt_reg);
        flush_res.flush_data  = rd_data;
        flush_res.last        = (word_cnt_reg == mdc_pkg::LAST_WORD);
    end

    // Sequencer: next state, memory writes and the output register load.
    always_comb begin
        state_next      = state_reg;
        word_cnt_next   = word_cnt_reg;
        pend_addr_next  = pend_addr_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        tag_wr          = tag_wr_look;
        data_wr         = data_wr_look;
        tag_wr.en       = 1'b0;
        data_wr.en      = 1'b0;

        case (state_reg)
            mdc_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = mdc_pkg::ST_LOOK;
                end
            end
            mdc_pkg::ST_LOOK: begin
                if (out_free) begin
                    tag_wr.en       = tag_wr_look.en;
                    data_wr.en      = data_wr_look.en;
                    pend_addr_next  = pend_addr_look;
                    pend_valid_next = pend_valid_look;
                    if (flush_start) begin
                        word_cnt_next = '0;
                        state_next    = mdc_pkg::ST_FREAD;
                    end else begin
                        m_valid_next = 1'b1;
                        m_item_next  = look_res;
                        state_next   = mdc_pkg::ST_IDLE;
                    end
                end
            end
            mdc_pkg::ST_FREAD: begin
                state_next = mdc_pkg::ST_FEMIT;
            end
            mdc_pkg::ST_FEMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = flush_res;
                    if (word_cnt_reg == mdc_pkg::LAST_WORD) begin
                        state_next = mdc_pkg::ST_IDLE;
                    end else begin
                        word_cnt_next = word_cnt_reg + mdc_pkg::WORD_W'(1);
                        state_next    = mdc_pkg::ST_FREAD;
                    end
                end
            end
            default: begin
                state_next = mdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mdc_pkg::ST_IDLE;
            word_cnt_reg   <= '0;
            own_id_reg     <= '0;
            pend_addr_reg  <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            word_cnt_reg   <= word_cnt_next;
            pend_addr_reg  <= pend_addr_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                own_id_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg <= s_item;
        end
        m_item_reg <= m_item_next;
    end

    // Only flush words may leave the last flag clear.
    a_not_last_is_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_item_reg.last |-> m_item_reg.flush_valid)
        else $error("result without last flag is not a flush word");

    // While a flush is running, a waiting flush word belongs to the snooped set.
    a_flush_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.flush_valid &&
        (state_reg == mdc_pkg::ST_FREAD || state_reg == mdc_pkg::ST_FEMIT) |->
        mdc_pkg::set_of(m_item_reg.flush_addr) == item_set)
        else $error("flush word address outside the snooped set");

    // A stalled flush word keeps its word counter.
    a_flush_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mdc_pkg::ST_FEMIT && !out_free |=> $stable(word_cnt_reg))
        else $error("flush word counter moved during a stall");

    // A hit never comes with a bus read request.
    a_hit_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.hit |-> m_item_reg.bus_request != mdc_pkg::REQ_READ)
        else $error("hit reported together with a bus read request");

endmodule
`default_nettype wire
